FILE: src/esg_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the exponential sine sweep generator.
package esg_pkg;

	localparam int PHASE_BITS      = 48;
	localparam int TABLE_ADDR_BITS = 10;
	localparam int SAMPLE_BITS     = 16;
	localparam int GROWTH_BITS     = 32;
	localparam int CFG_INDEX_BITS  = 4;
	localparam int CFG_DATA_BITS   = 48;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);

	localparam logic [PHASE_BITS-1:0]  HALF_CYCLE    = {1'b1, {(PHASE_BITS-1){1'b0}}};
	localparam logic [PHASE_BITS-1:0]  START_RESET   = 48'd127653050663;
	localparam logic [GROWTH_BITS-1:0] GROWTH_RESET  = 32'd2235620000;

	localparam logic [CFG_INDEX_BITS-1:0] REG_START_INCREMENT = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_GROWTH          = 4'd1;

	// Phase slice that the sine lookup needs (quadrant and table index) and the increment.
	typedef struct packed {
		logic [1:0]                 quad;
		logic [TABLE_ADDR_BITS-1:0] idx;
		logic [PHASE_BITS-1:0]      inc;
	} esg_entry_t;

endpackage

FILE: src/esg_front.sv
`timescale 1ns / 1ps
// Front part: request intake, configuration registers and the phase/increment recurrence.
module esg_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic                                 restart,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [esg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [esg_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	input  logic                                 queue_full,
	output logic                                 push,
	output esg_pkg::esg_entry_t                  push_entry
);
	import esg_pkg::*;

	localparam int LO_BITS   = 32;
	localparam int HI_BITS   = PHASE_BITS - LO_BITS;
	localparam int PROD_BITS = PHASE_BITS + GROWTH_BITS;

	logic [PHASE_BITS-1:0]  start_q;
	logic [GROWTH_BITS-1:0] growth_q;
	logic [PHASE_BITS-1:0]  phase_q;
	logic [PHASE_BITS-1:0]  inc_q;

	logic                   accept;
	logic [PHASE_BITS-1:0]  cur_phase;
	logic [PHASE_BITS-1:0]  cur_inc;
	logic [LO_BITS+GROWTH_BITS-1:0] prod_lo;
	logic [HI_BITS+GROWTH_BITS-1:0] prod_hi;
	logic [PROD_BITS-1:0]   prod;
	logic [GROWTH_BITS-1:0] delta;
	logic [PHASE_BITS:0]    grown;
	logic [PHASE_BITS-1:0]  next_inc;

	assign cfg_ready  = 1'b1;
	assign item_stall = queue_full;
	assign accept     = item_valid && !queue_full;
	assign push       = accept;

	always_comb begin
		cur_phase = restart ? '0 : phase_q;
		cur_inc   = restart ? start_q : inc_q;
		// Increment times growth, split into two partial products.
		prod_lo   = cur_inc[LO_BITS-1:0] * growth_q;
		prod_hi   = cur_inc[PHASE_BITS-1:LO_BITS] * growth_q;
		prod      = {prod_hi, {LO_BITS{1'b0}}} + {{HI_BITS{1'b0}}, prod_lo};
		delta     = prod[PROD_BITS-1:PHASE_BITS];
		grown     = {1'b0, cur_inc} + {{(PHASE_BITS+1-GROWTH_BITS){1'b0}}, delta};
		next_inc  = (grown >= {1'b0, HALF_CYCLE}) ? HALF_CYCLE : grown[PHASE_BITS-1:0];
		push_entry.quad = cur_phase[PHASE_BITS-1 -: 2];
		push_entry.idx  = cur_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
		push_entry.inc  = cur_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= START_RESET;
			growth_q <= GROWTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_START_INCREMENT: begin
					// Only the clamped value is ever used, so clamp on write.
					start_q <= (cfg_data > HALF_CYCLE) ? HALF_CYCLE : cfg_data;
				end
				REG_GROWTH: begin
					growth_q <= cfg_data[GROWTH_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			inc_q   <= START_RESET;
		end else if (accept) begin
			phase_q <= cur_phase + cur_inc;
			inc_q   <= next_inc;
		end
	end

endmodule

FILE: src/esg_queue.sv
`timescale 1ns / 1ps
// Short queue of phase/increment entries between the front and back parts.
module esg_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  esg_pkg::esg_entry_t push_entry,
	input  logic                pop,
	output esg_pkg::esg_entry_t head,
	output logic                full,
	output logic                empty
);
	import esg_pkg::*;

	esg_entry_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_PTR_BITS:0]   count_q;

	assign full  = (count_q == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/esg_back.sv
`timescale 1ns / 1ps
// Back part: quarter-wave sine table lookup, sign fold and output register.
module esg_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  empty,
	input  esg_pkg::esg_entry_t                   head,
	output logic                                  pop,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic signed [esg_pkg::SAMPLE_BITS-1:0] sample_value,
	output logic [esg_pkg::PHASE_BITS-1:0]        current_increment
);
	import esg_pkg::*;

	localparam int ROM_SIZE = 1 << TABLE_ADDR_BITS;
	localparam longint AMPLITUDE = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned SERIES_DIV [6] = '{6, 20, 42, 72, 110, 156};

	typedef logic [SAMPLE_BITS-2:0] rom_word_t;
	typedef rom_word_t rom_array_t [ROM_SIZE];

	// Sine of the middle of table step i over a quarter cycle, Q30 Taylor series.
	function automatic rom_word_t rom_entry(input int unsigned i);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		longint s;
		x    = ((longint'(i) * 2 + 1) * HALF_PI_Q30) >> (TABLE_ADDR_BITS + 1);
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (int n = 1; n <= 6; n++) begin
			term = ((term * x2) >> 30) / SERIES_DIV[n-1];
			if (n % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		s = (sum * AMPLITUDE + (longint'(1) << 29)) >>> 30;
		if (s > AMPLITUDE) begin
			s = AMPLITUDE;
		end
		return rom_word_t'(s);
	endfunction

	function automatic rom_array_t build_rom();
		rom_array_t t;
		for (int i = 0; i < ROM_SIZE; i++) begin
			t[i] = rom_entry(i);
		end
		return t;
	endfunction

	localparam rom_array_t SINE_ROM = build_rom();

	logic                        valid_s1;
	logic                        neg_s1;
	rom_word_t                   rom_data_s1;
	logic [PHASE_BITS-1:0]       inc_s1;
	logic                        valid_s2;
	logic signed [SAMPLE_BITS-1:0] sample_s2;
	logic [PHASE_BITS-1:0]       inc_s2;

	logic                        load_s1;
	logic                        load_s2;
	logic [TABLE_ADDR_BITS-1:0]  rom_addr;
	logic signed [SAMPLE_BITS-1:0] magnitude;

	assign load_s2  = !valid_s2 || !result_stall;
	assign load_s1  = !valid_s1 || load_s2;
	assign pop      = load_s1 && !empty;
	// Odd quadrants run the table backwards.
	assign rom_addr = head.quad[0] ? ~head.idx : head.idx;
	assign magnitude = {1'b0, rom_data_s1};

	assign result_valid      = valid_s2;
	assign sample_value      = sample_s2;
	assign current_increment = inc_s2;

	always_ff @(posedge clk) begin
		if (load_s1) begin
			rom_data_s1 <= SINE_ROM[rom_addr];
			neg_s1      <= head.quad[1];
			inc_s1      <= head.inc;
		end
		if (load_s2) begin
			sample_s2 <= neg_s1 ? -magnitude : magnitude;
			inc_s2    <= inc_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= !empty;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

endmodule

FILE: src/exponential_sine_sweep_generator.sv
`timescale 1ns / 1ps
// Top level of the exponential sine sweep generator.
//
//   channel   signals                                   role
//   request   item_valid, item_stall, restart           one sample per request
//   result    result_valid, result_stall,
//             sample_value, current_increment           one result per request
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data register writes
//
// One request per cycle is taken unless the queue is full; the front updates its phase and
// increment registers on each accepted request, the 48x32 growth product being formed
// combinationally as two partial products. A result passes through the queue, the registered
// sine table read and the output register.
// Reset clears the phase, loads the reset start increment and empties the four-entry queue.
// item_stall rises only when the queue is full; result_stall holds the output register.
module exponential_sine_sweep_generator (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   item_valid,
	output logic                                   item_stall,
	input  logic                                   restart,
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output logic signed [esg_pkg::SAMPLE_BITS-1:0] sample_value,
	output logic [esg_pkg::PHASE_BITS-1:0]         current_increment,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [esg_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [esg_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
	import esg_pkg::*;

	logic       push;
	esg_entry_t push_entry;
	logic       pop;
	esg_entry_t head;
	logic       queue_full;
	logic       queue_empty;

	esg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.restart    (restart),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	esg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (queue_full),
		.empty      (queue_empty)
	);

	esg_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.empty             (queue_empty),
		.head              (head),
		.pop               (pop),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.sample_value      (sample_value),
		.current_increment (current_increment)
	);

endmodule

FILE: src/esg_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the exponential sine sweep generator and their binding.
module esg_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   item_stall,
	input logic                                   result_valid,
	input logic                                   result_stall,
	input logic signed [esg_pkg::SAMPLE_BITS-1:0] sample_value,
	input logic [esg_pkg::PHASE_BITS-1:0]         current_increment
);
	import esg_pkg::*;

	// The increment saturates at half a cycle per sample.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (current_increment <= HALF_CYCLE))
		else $error("increment above half a cycle");

	// Samples are symmetric about zero, so the most negative code never appears.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (sample_value != {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
		else $error("sample outside symmetric range");

	// A stalled result stays in place.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(sample_value) && $stable(current_increment))
		else $error("stalled result changed");

	// With the output flowing, the queue never fills, so requests are never held off.
	assert property (@(posedge clk) disable iff (!arst_n)
		!result_stall && $past(!result_stall) && $past(!result_stall, 2)
			&& $past(!result_stall, 3) && $past(!result_stall, 4) |-> !item_stall)
		else $error("request stalled while results flow");

endmodule

bind exponential_sine_sweep_generator esg_checker u_esg_checker (.*);
